@@ src/cehr_pkg.sv @@
// Shared types, constants and codes for the contact event history replay block.
// Used by every module in src; depends on nothing.
package cehr_pkg;

	localparam int DEF_HISTORY_DEPTH     = 8;
	localparam int DEF_REDUCED_TIME_BITS = 16;

	localparam int MODE_W  = 2;
	localparam int UPD_W   = 8;
	localparam int WORD_W  = 32;
	localparam int KIND_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_SENSE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INIT   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_REC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SUM = 2'd3;

	localparam logic REG_COLLAPSE = 1'b0;
	localparam logic REG_NOTIFY   = 1'b1;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OP_W-1:0] OP_REC    = 4'd2;
	localparam logic [OP_W-1:0] OP_RDCNT  = 4'd3;
	localparam logic [OP_W-1:0] OP_TDIFF  = 4'd4;
	localparam logic [OP_W-1:0] OP_LATEST = 4'd5;
	localparam logic [OP_W-1:0] OP_PREP   = 4'd6;
	localparam logic [OP_W-1:0] OP_RD     = 4'd7;
	localparam logic [OP_W-1:0] OP_SETPD  = 4'd8;
	localparam logic [OP_W-1:0] OP_ACC    = 4'd9;
	localparam logic [OP_W-1:0] OP_EVT    = 4'd10;
	localparam logic [OP_W-1:0] OP_MVEO   = 4'd11;
	localparam logic [OP_W-1:0] OP_BSTEP  = 4'd12;

	typedef struct packed {
		logic collapse;
		logic notify;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              emit;
		logic [KIND_W-1:0] okind;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              changed;
		logic              upd_hi;
		logic              upd0;
		logic              nz;
		logic              lost;
		logic              nd_zero;
		logic              rem_zero;
		logic              rem_one;
		logic              run_ne;
		logic              emit_ok;
	} sts_t;

endpackage

@@ src/cehr_regs.sv @@
// APB-style configuration registers: collapse mode and notify enable.
// Depends on cehr_pkg.
module cehr_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cehr_pkg::PADDR_W-1:0]    paddr,
	input  logic [cehr_pkg::PDATA_W-1:0]    pwdata,
	output logic [cehr_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	output cehr_pkg::cfg_t                  cfg
);

	logic collapse_q;
	logic notify_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collapse_q <= 1'b0;
			notify_q   <= 1'b1;
		end else if (wr) begin
			if (paddr[2] == cehr_pkg::REG_COLLAPSE) begin
				collapse_q <= pwdata[0];
			end else begin
				notify_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == cehr_pkg::REG_COLLAPSE) begin
			prdata[0] = collapse_q;
		end else begin
			prdata[0] = notify_q;
		end
	end

	assign cfg.collapse = collapse_q;
	assign cfg.notify   = notify_q;

endmodule

@@ src/cehr_dp.sv @@
// Datapath: event counter, timestamp ring memory, replay arithmetic, result register.
// Driven by cehr_ctrl through cmd_t; depends on cehr_pkg.
module cehr_dp #(
	parameter int HISTORY_DEPTH     = cehr_pkg::DEF_HISTORY_DEPTH,
	parameter int REDUCED_TIME_BITS = cehr_pkg::DEF_REDUCED_TIME_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cehr_pkg::cfg_t                  cfg,
	input  cehr_pkg::cmd_t                  cmd,
	output cehr_pkg::sts_t                  sts,
	input  logic [cehr_pkg::MODE_W-1:0]     mode,
	input  logic [cehr_pkg::UPD_W-1:0]      level_updates,
	input  logic [cehr_pkg::WORD_W-1:0]     now_time,
	input  logic [cehr_pkg::WORD_W-1:0]     prev_ordinal,
	input  logic [cehr_pkg::WORD_W-1:0]     prev_latest_time,
	output logic [cehr_pkg::KIND_W-1:0]     kind,
	output logic [cehr_pkg::WORD_W-1:0]     event_ordinal,
	output logic [cehr_pkg::WORD_W-1:0]     event_time,
	output logic [cehr_pkg::WORD_W-1:0]     run_length,
	output logic [cehr_pkg::WORD_W-1:0]     elapsed,
	output logic                            last
);

	localparam int IW  = $clog2(HISTORY_DEPTH);
	localparam int RTB = REDUCED_TIME_BITS;
	localparam int WW  = cehr_pkg::WORD_W;

	logic [RTB-1:0] mem [HISTORY_DEPTH];
	logic [RTB-1:0] mem_rd_q;
	logic [HISTORY_DEPTH-1:0] vld_q;
	logic rdv_q;

	logic [WW-1:0] cnt_q;
	logic [cehr_pkg::MODE_W-1:0] mode_q;
	logic [cehr_pkg::UPD_W-1:0]  upd_q;
	logic [WW-1:0] now_q;
	logic [WW-1:0] pord_q;
	logic [WW-1:0] ptime_q;
	logic [WW-1:0] nevt_q;
	logic [WW-1:0] latest_q;
	logic [WW-1:0] sum_q;
	logic [WW-1:0] evt_q;
	logic [WW-1:0] eo_q;
	logic [WW-1:0] neo_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] nd_q;
	logic [IW-1:0] rem_q;
	logic [RTB-1:0] tdiff_q;
	logic [RTB-1:0] pd_q;
	logic lost_q;
	logic emit_q;

	logic [cehr_pkg::KIND_W-1:0] kind_q;
	logic [WW-1:0] ord_q;
	logic [WW-1:0] time_q;
	logic [WW-1:0] run_q;
	logic [WW-1:0] el_q;
	logic          last_q;

	logic [WW-1:0]  cnt_inc;
	logic [IW-1:0]  rd_addr;
	logic [RTB-1:0] rdat;
	logic [RTB-1:0] dlt;
	logic           few;
	logic           par_same;
	logic           rd_en;

	assign cnt_inc  = cnt_q + 32'd1;
	assign rd_addr  = (cmd.op == cehr_pkg::OP_RDCNT) ? cnt_q[IW-1:0] : ptr_q;
	assign rd_en    = (cmd.op == cehr_pkg::OP_RDCNT) || (cmd.op == cehr_pkg::OP_RD);
	assign rdat     = rdv_q ? mem_rd_q : '0;
	assign dlt      = lost_q ? '0 : (rdat - pd_q);
	assign few      = nevt_q < WW'(HISTORY_DEPTH);
	assign par_same = ~(cnt_q[0] ^ pord_q[0]);

	always_ff @(posedge clk) begin
		if (cmd.op == cehr_pkg::OP_REC) begin
			mem[cnt_inc[IW-1:0]] <= now_q[RTB-1:0];
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '1;
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (cmd.op == cehr_pkg::OP_REC) begin
				cnt_q <= cnt_inc;
				vld_q[cnt_inc[IW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rdv_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			cehr_pkg::OP_LOAD: begin
				mode_q  <= mode;
				upd_q   <= level_updates;
				now_q   <= now_time;
				pord_q  <= prev_ordinal;
				ptime_q <= prev_latest_time;
			end
			cehr_pkg::OP_RDCNT: begin
				nevt_q <= cnt_q - pord_q;
				eo_q   <= pord_q + 32'd1;
			end
			cehr_pkg::OP_TDIFF: begin
				tdiff_q <= now_q[RTB-1:0] - rdat;
			end
			cehr_pkg::OP_LATEST: begin
				latest_q <= now_q - WW'(tdiff_q);
				lost_q   <= ~few;
				if (few) begin
					nd_q <= nevt_q[IW-1:0] - IW'(1);
				end else if (par_same) begin
					nd_q <= IW'(1);
				end else begin
					nd_q <= '0;
				end
			end
			cehr_pkg::OP_PREP: begin
				neo_q <= cnt_q - WW'(nd_q);
				ptr_q <= eo_q[IW-1:0];
				sum_q <= '0;
				rem_q <= nd_q;
			end
			cehr_pkg::OP_RD: begin
				ptr_q <= ptr_q + IW'(1);
			end
			cehr_pkg::OP_SETPD: begin
				pd_q <= rdat;
			end
			cehr_pkg::OP_ACC: begin
				sum_q <= sum_q + WW'(dlt);
				pd_q  <= rdat;
				rem_q <= rem_q - IW'(1);
			end
			cehr_pkg::OP_EVT: begin
				evt_q <= latest_q - sum_q;
				ptr_q <= neo_q[IW-1:0];
				rem_q <= nd_q;
			end
			cehr_pkg::OP_MVEO: begin
				eo_q <= neo_q;
			end
			cehr_pkg::OP_BSTEP: begin
				evt_q  <= evt_q + WW'(dlt);
				eo_q   <= eo_q + 32'd1;
				pd_q   <= rdat;
				rem_q  <= rem_q - IW'(1);
				emit_q <= ~cfg.collapse || (dlt != '0) || (rem_q == IW'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.okind;
			case (cmd.okind)
				cehr_pkg::KIND_REC: begin
					ord_q  <= cnt_q;
					time_q <= now_q;
					run_q  <= '0;
					el_q   <= '0;
					last_q <= 1'b1;
				end
				cehr_pkg::KIND_EVT: begin
					ord_q  <= eo_q;
					time_q <= evt_q;
					run_q  <= '0;
					el_q   <= '0;
					last_q <= 1'b0;
				end
				cehr_pkg::KIND_RUN: begin
					ord_q  <= eo_q + 32'd1;
					time_q <= evt_q;
					run_q  <= neo_q - eo_q;
					el_q   <= '0;
					last_q <= 1'b0;
				end
				default: begin
					ord_q  <= cnt_q;
					time_q <= latest_q;
					run_q  <= '0;
					el_q   <= (nevt_q != '0) ? (latest_q - ptime_q) : '0;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign sts.mode     = mode_q;
	assign sts.changed  = upd_q[0] ^ cnt_q[0];
	assign sts.upd_hi   = |upd_q[cehr_pkg::UPD_W-1:1];
	assign sts.upd0     = upd_q[0];
	assign sts.nz       = nevt_q != '0;
	assign sts.lost     = lost_q;
	assign sts.nd_zero  = nd_q == '0;
	assign sts.rem_zero = rem_q == '0;
	assign sts.rem_one  = rem_q == IW'(1);
	assign sts.run_ne   = neo_q != eo_q;
	assign sts.emit_ok  = emit_q;

	assign kind          = kind_q;
	assign event_ordinal = ord_q;
	assign event_time    = time_q;
	assign run_length    = run_q;
	assign elapsed       = el_q;
	assign last          = last_q;

endmodule

@@ src/cehr_ctrl.sv @@
// Controller: sequences record and replay steps, owns both handshakes.
// Commands cehr_dp through cmd_t and reads sts_t; depends on cehr_pkg.
module cehr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  cehr_pkg::cfg_t     cfg,
	input  cehr_pkg::sts_t     sts,
	output cehr_pkg::cmd_t     cmd,
	input  logic               item_valid,
	output logic               item_ready,
	output logic               res_valid,
	input  logic               res_ready
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DEC  = 5'd1;
	localparam logic [4:0] S_REC1 = 5'd2;
	localparam logic [4:0] S_REC2 = 5'd3;
	localparam logic [4:0] S_EM0  = 5'd4;
	localparam logic [4:0] S_RP0  = 5'd5;
	localparam logic [4:0] S_RP1  = 5'd6;
	localparam logic [4:0] S_RP2  = 5'd7;
	localparam logic [4:0] S_RP3  = 5'd8;
	localparam logic [4:0] S_ARD0 = 5'd9;
	localparam logic [4:0] S_APD  = 5'd10;
	localparam logic [4:0] S_ARD  = 5'd11;
	localparam logic [4:0] S_AACC = 5'd12;
	localparam logic [4:0] S_AEND = 5'd13;
	localparam logic [4:0] S_EMF  = 5'd14;
	localparam logic [4:0] S_RUN  = 5'd15;
	localparam logic [4:0] S_BRD0 = 5'd16;
	localparam logic [4:0] S_BPD  = 5'd17;
	localparam logic [4:0] S_BRD  = 5'd18;
	localparam logic [4:0] S_BST  = 5'd19;
	localparam logic [4:0] S_EMB  = 5'd20;
	localparam logic [4:0] S_SUM  = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       dbl_q;
	logic       dbl_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free   = ~out_valid_q | res_ready;
	assign item_ready = state_q == S_IDLE;
	assign res_valid  = out_valid_q;

	always_comb begin
		state_d   = state_q;
		dbl_d     = dbl_q;
		cmd.op    = cehr_pkg::OP_NONE;
		cmd.emit  = 1'b0;
		cmd.okind = cehr_pkg::KIND_REC;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.op  = cehr_pkg::OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.mode)
					cehr_pkg::MODE_SENSE: begin
						if (!sts.changed && !sts.upd_hi) begin
							state_d = S_IDLE;
						end else begin
							dbl_d   = ~sts.changed;
							state_d = S_REC1;
						end
					end
					cehr_pkg::MODE_INIT: begin
						dbl_d   = sts.upd0;
						state_d = S_REC1;
					end
					cehr_pkg::MODE_REPLAY: begin
						state_d = S_RP0;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_REC1: begin
				cmd.op  = cehr_pkg::OP_REC;
				state_d = dbl_q ? S_REC2 : S_EM0;
			end
			S_REC2: begin
				cmd.op  = cehr_pkg::OP_REC;
				state_d = S_EM0;
			end
			S_EM0: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					cmd.okind = cehr_pkg::KIND_REC;
					state_d   = S_IDLE;
				end
			end
			S_RP0: begin
				cmd.op  = cehr_pkg::OP_RDCNT;
				state_d = S_RP1;
			end
			S_RP1: begin
				cmd.op  = cehr_pkg::OP_TDIFF;
				state_d = S_RP2;
			end
			S_RP2: begin
				cmd.op  = cehr_pkg::OP_LATEST;
				state_d = S_RP3;
			end
			S_RP3: begin
				if (!sts.nz || !cfg.notify) begin
					state_d = S_SUM;
				end else begin
					cmd.op  = cehr_pkg::OP_PREP;
					state_d = (sts.lost || sts.nd_zero) ? S_AEND : S_ARD0;
				end
			end
			S_ARD0: begin
				cmd.op  = cehr_pkg::OP_RD;
				state_d = S_APD;
			end
			S_APD: begin
				cmd.op  = cehr_pkg::OP_SETPD;
				state_d = S_ARD;
			end
			S_ARD: begin
				cmd.op  = cehr_pkg::OP_RD;
				state_d = S_AACC;
			end
			S_AACC: begin
				cmd.op  = cehr_pkg::OP_ACC;
				state_d = sts.rem_one ? S_AEND : S_ARD;
			end
			S_AEND: begin
				cmd.op  = cehr_pkg::OP_EVT;
				state_d = S_EMF;
			end
			S_EMF: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					cmd.okind = cehr_pkg::KIND_EVT;
					state_d   = S_RUN;
				end
			end
			S_RUN: begin
				if (!cfg.collapse && sts.run_ne) begin
					if (out_free) begin
						cmd.emit  = 1'b1;
						cmd.okind = cehr_pkg::KIND_RUN;
						cmd.op    = cehr_pkg::OP_MVEO;
						state_d   = S_BRD0;
					end
				end else begin
					cmd.op  = cehr_pkg::OP_MVEO;
					state_d = S_BRD0;
				end
			end
			S_BRD0: begin
				if (sts.rem_zero) begin
					state_d = S_SUM;
				end else begin
					cmd.op  = cehr_pkg::OP_RD;
					state_d = S_BPD;
				end
			end
			S_BPD: begin
				cmd.op  = cehr_pkg::OP_SETPD;
				state_d = S_BRD;
			end
			S_BRD: begin
				cmd.op  = cehr_pkg::OP_RD;
				state_d = S_BST;
			end
			S_BST: begin
				cmd.op  = cehr_pkg::OP_BSTEP;
				state_d = S_EMB;
			end
			S_EMB: begin
				if (!sts.emit_ok) begin
					state_d = sts.rem_zero ? S_SUM : S_BRD;
				end else if (out_free) begin
					cmd.emit  = 1'b1;
					cmd.okind = cehr_pkg::KIND_EVT;
					state_d   = sts.rem_zero ? S_SUM : S_BRD;
				end
			end
			S_SUM: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					cmd.okind = cehr_pkg::KIND_SUM;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dbl_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dbl_q   <= dbl_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/contact_event_history_replay_top.sv @@
// Top level of the contact event history replay block.
// Instantiates cehr_regs, cehr_ctrl and cehr_dp; depends on cehr_pkg.
//
//   port group   handshake                 payload
//   config       psel/penable/pwrite       paddr, pwdata -> prdata, pready
//   item in      item_valid/item_ready     mode, level_updates, now_time,
//                                          prev_ordinal, prev_latest_time
//   result out   res_valid/res_ready       kind, event_ordinal, event_time,
//                                          run_length, elapsed, last
//
// Sense and init items are loaded, decoded and recorded once or twice before their
// result is registered; a sense item that needs no record returns to idle without one.
// Replay rebuilds deltas through the single ring read port and its registered read data.
// Reset clears the counter to all ones and the ring valid bits; no clearing pass.
// A stalled result holds the block at its next emit step; item_ready is high in idle.
module contact_event_history_replay_top #(
	parameter int HISTORY_DEPTH     = cehr_pkg::DEF_HISTORY_DEPTH,
	parameter int REDUCED_TIME_BITS = cehr_pkg::DEF_REDUCED_TIME_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cehr_pkg::PADDR_W-1:0]    paddr,
	input  logic [cehr_pkg::PDATA_W-1:0]    pwdata,
	output logic [cehr_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [cehr_pkg::MODE_W-1:0]     mode,
	input  logic [cehr_pkg::UPD_W-1:0]      level_updates,
	input  logic [cehr_pkg::WORD_W-1:0]     now_time,
	input  logic [cehr_pkg::WORD_W-1:0]     prev_ordinal,
	input  logic [cehr_pkg::WORD_W-1:0]     prev_latest_time,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [cehr_pkg::KIND_W-1:0]     kind,
	output logic [cehr_pkg::WORD_W-1:0]     event_ordinal,
	output logic [cehr_pkg::WORD_W-1:0]     event_time,
	output logic [cehr_pkg::WORD_W-1:0]     run_length,
	output logic [cehr_pkg::WORD_W-1:0]     elapsed,
	output logic                            last
);

	cehr_pkg::cfg_t cfg;
	cehr_pkg::cmd_t cmd;
	cehr_pkg::sts_t sts;

	cehr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cehr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.sts        (sts),
		.cmd        (cmd),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	cehr_dp #(
		.HISTORY_DEPTH     (HISTORY_DEPTH),
		.REDUCED_TIME_BITS (REDUCED_TIME_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.level_updates    (level_updates),
		.now_time         (now_time),
		.prev_ordinal     (prev_ordinal),
		.prev_latest_time (prev_latest_time),
		.kind             (kind),
		.event_ordinal    (event_ordinal),
		.event_time       (event_time),
		.run_length       (run_length),
		.elapsed          (elapsed),
		.last             (last)
	);

endmodule
